// ----- hw/rtl/dtsh_pkg.sv -----
// ----------------------------------------------------------------------------
// dtsh_pkg
// Shared types and constants of the depth threshold sharing histogram.
// ----------------------------------------------------------------------------
package dtsh_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int MAX_FILTERS = 16;
	localparam int DEPTH_BITS  = 16;
	localparam int COUNT_BITS  = 32;

	localparam int SAMP_AW = $clog2(MAX_SAMPLES);
	localparam int FILT_AW = $clog2(MAX_FILTERS);
	localparam int PASS_W  = $clog2(MAX_SAMPLES + 1);
	localparam int THR_W   = DEPTH_BITS + FILT_AW;

	localparam logic [PASS_W-1:0]     PASS_MAX  = PASS_W'(MAX_SAMPLES);
	localparam logic [SAMP_AW-1:0]    ADDR_LAST = SAMP_AW'(MAX_SAMPLES - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// configuration register indexes
	localparam logic [1:0] REG_MIN_DEPTH  = 2'd0;
	localparam logic [1:0] REG_MAX_DEPTH  = 2'd1;
	localparam logic [1:0] REG_DEPTH_STEP = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_READ
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_REC,
		OP_CLR,
		OP_UPD
	} op_t;

	// broadcast command from the sequencer to every cell
	typedef struct packed {
		op_t                   op;
		logic [SAMP_AW-1:0]    addr;
		logic                  last;
		logic [DEPTH_BITS-1:0] depth;
	} cell_ctl_t;

	// threshold link from one cell to its right neighbor
	typedef struct packed {
		logic                  ok;
		logic [DEPTH_BITS-1:0] thr;
	} link_t;

	// what each cell reports back to the top
	typedef struct packed {
		logic                  present;
		logic [DEPTH_BITS-1:0] thr;
		logic [COUNT_BITS-1:0] rd;
	} cell_out_t;

endpackage

// ----- hw/rtl/depth_threshold_sharing_histogram_top.sv -----
// ----------------------------------------------------------------------------
// depth_threshold_sharing_histogram_top
// Depth threshold sharing histogram over a row of threshold cells.
// ----------------------------------------------------------------------------
// Usage:
// s_axis carries one beat per item. tuser = kind (0 record, 1 read),
// tlast = last record of a position, tdata = depth, sample_count,
// filter_index. Records give no result; a read gives one m_axis beat with
// the share count, threshold and the filter-present flag in tuser.
// cfg writes min_depth, max_depth and depth_step by index.
// Flow: a record without tlast leaves the block ready for the next item.
// A record with tlast starts a sweep of all share counter banks in parallel,
// one address per cycle, through the counter bank read-modify-write port;
// no item is taken during it. A read goes through the registered bank read, then the output register.
// Reset: a clearing pass over all MAX_SAMPLES addresses zeroes all banks; no item is
// taken meanwhile, config writes are.
// Stall: a held result blocks only further reads; records keep flowing.
// ----------------------------------------------------------------------------
module depth_threshold_sharing_histogram_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // depth[15:0], sample_count[22:16], filter_index[26:23]
	input  logic        s_axis_tlast,
	input  logic        s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // count[31:0], threshold[47:32]
	output logic        m_axis_tuser,  // filter_present
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	dtsh_pkg::state_t                state_q, state_nxt;
	logic [dtsh_pkg::SAMP_AW-1:0]    cnt_q;
	logic [15:0]                     min_q, max_q, step_q;
	logic [dtsh_pkg::FILT_AW-1:0]    fi_q;
	logic                            sc_ok_q;
	logic                            out_valid_q;
	logic [31:0]                     out_count_q;
	logic [15:0]                     out_thr_q;
	logic                            out_pres_q;

	logic                            s_accept;
	logic [6:0]                      in_sc;
	dtsh_pkg::cell_ctl_t             ctl;
	dtsh_pkg::link_t                 links [dtsh_pkg::MAX_FILTERS+1];
	dtsh_pkg::cell_out_t             stats [dtsh_pkg::MAX_FILTERS];
	dtsh_pkg::cell_out_t             sel;

	assign in_sc    = s_axis_tdata[22:16];
	assign s_accept = s_axis_tvalid && s_axis_tready;

	// cell row
	assign links[0].ok  = 1'b0;
	assign links[0].thr = '0;
	for (genvar g = 0; g < dtsh_pkg::MAX_FILTERS; g++) begin : g_cell
		dtsh_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (dtsh_pkg::FILT_AW'(g)),
			.min_depth  (min_q),
			.max_depth  (max_q),
			.depth_step (step_q),
			.link_in    (links[g]),
			.link_out   (links[g+1]),
			.ctl        (ctl),
			.stat       (stats[g])
		);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= 16'd10;
			max_q  <= 16'd40;
			step_q <= 16'd9;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dtsh_pkg::REG_MIN_DEPTH:  min_q  <= cfg_data;
				dtsh_pkg::REG_MAX_DEPTH:  max_q  <= cfg_data;
				dtsh_pkg::REG_DEPTH_STEP: step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dtsh_pkg::ST_CLEAR: if (cnt_q == dtsh_pkg::ADDR_LAST) state_nxt = dtsh_pkg::ST_IDLE;
			dtsh_pkg::ST_IDLE: begin
				if (s_accept && s_axis_tuser) state_nxt = dtsh_pkg::ST_READ;
				else if (s_accept && s_axis_tlast) state_nxt = dtsh_pkg::ST_SWEEP;
			end
			dtsh_pkg::ST_SWEEP: if (cnt_q == dtsh_pkg::ADDR_LAST) state_nxt = dtsh_pkg::ST_DRAIN;
			dtsh_pkg::ST_DRAIN: state_nxt = dtsh_pkg::ST_IDLE;
			dtsh_pkg::ST_READ:  state_nxt = dtsh_pkg::ST_IDLE;
			default:            state_nxt = dtsh_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctl.op        = dtsh_pkg::OP_NONE;
		ctl.addr      = cnt_q;
		ctl.last      = 1'b0;
		ctl.depth     = s_axis_tdata[15:0];
		s_axis_tready = 1'b0;
		cfg_ready     = 1'b0;
		case (state_q)
			dtsh_pkg::ST_CLEAR: begin
				ctl.op    = dtsh_pkg::OP_CLR;
				cfg_ready = 1'b1;
			end
			dtsh_pkg::ST_IDLE: begin
				ctl.addr      = dtsh_pkg::SAMP_AW'(in_sc - 7'd1);
				s_axis_tready = !s_axis_tuser || !out_valid_q;
				cfg_ready     = 1'b1;
				if (s_accept && !s_axis_tuser) ctl.op = dtsh_pkg::OP_REC;
			end
			dtsh_pkg::ST_SWEEP: begin
				ctl.op   = dtsh_pkg::OP_UPD;
				ctl.last = (cnt_q == dtsh_pkg::ADDR_LAST);
			end
			default: ;
		endcase
	end

	// state, sweep counter, read context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtsh_pkg::ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == dtsh_pkg::ST_CLEAR || state_q == dtsh_pkg::ST_SWEEP)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			fi_q    <= s_axis_tdata[26:23];
			sc_ok_q <= (in_sc >= 7'd1) && (in_sc <= 7'(dtsh_pkg::MAX_SAMPLES));
		end
	end

	// output register
	assign sel = stats[fi_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == dtsh_pkg::ST_READ) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dtsh_pkg::ST_READ) begin
			out_pres_q  <= sel.present;
			out_thr_q   <= sel.present ? sel.thr : 16'd0;
			out_count_q <= (sel.present && sc_ok_q) ? sel.rd[31:0] : 32'd0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_thr_q, out_count_q};
	assign m_axis_tuser  = out_pres_q;

	// checks
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == dtsh_pkg::ST_READ))
		else $error("result raised without a read");
	a_read_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_axis_tuser) |=> (state_q == dtsh_pkg::ST_READ))
		else $error("read beat not followed by lookup");
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dtsh_pkg::ST_SWEEP && cnt_q == dtsh_pkg::ADDR_LAST)
		|=> (state_q == dtsh_pkg::ST_DRAIN))
		else $error("sweep did not finish");

endmodule

// ----- hw/rtl/dtsh_cell.sv -----
// ----------------------------------------------------------------------------
// dtsh_cell
// One threshold cell: derives its threshold from the config and its left
// neighbor, counts passing samples and owns one bank of share counters.
// ----------------------------------------------------------------------------
module dtsh_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [dtsh_pkg::FILT_AW-1:0]        idx,
	input  logic [dtsh_pkg::DEPTH_BITS-1:0]     min_depth,
	input  logic [dtsh_pkg::DEPTH_BITS-1:0]     max_depth,
	input  logic [dtsh_pkg::DEPTH_BITS-1:0]     depth_step,
	input  dtsh_pkg::link_t                     link_in,
	output dtsh_pkg::link_t                     link_out,
	input  dtsh_pkg::cell_ctl_t                 ctl,
	output dtsh_pkg::cell_out_t                 stat
);

	logic [dtsh_pkg::THR_W-1:0]      t_full;
	logic                            loop_ok;
	logic                            appended;
	logic                            degen;
	logic                            present;
	logic [dtsh_pkg::DEPTH_BITS-1:0] thr;

	logic [dtsh_pkg::PASS_W-1:0]     pass_q;
	logic [dtsh_pkg::COUNT_BITS-1:0] mem [dtsh_pkg::MAX_SAMPLES];
	logic [dtsh_pkg::COUNT_BITS-1:0] rd_q;
	logic                            en_s1;
	logic [dtsh_pkg::SAMP_AW-1:0]    addr_s1;

	// threshold of this slot: min + idx * step, plus the appended max entry
	always_comb begin
		t_full   = dtsh_pkg::THR_W'(min_depth)
			+ dtsh_pkg::THR_W'(depth_step) * dtsh_pkg::THR_W'(idx);
		loop_ok  = (t_full <= dtsh_pkg::THR_W'(max_depth));
		degen    = (max_depth <= min_depth);
		appended = (idx != '0) && link_in.ok && !loop_ok && (link_in.thr != max_depth);
		present  = degen ? (idx == '0) : (loop_ok || appended);
		thr      = (degen || loop_ok) ? t_full[dtsh_pkg::DEPTH_BITS-1:0] : max_depth;
	end

	assign link_out.ok  = loop_ok && !degen;
	assign link_out.thr = t_full[dtsh_pkg::DEPTH_BITS-1:0];

	// per-position pass count, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= '0;
		end else if (ctl.op == dtsh_pkg::OP_UPD && ctl.last) begin
			pass_q <= '0;
		end else if (ctl.op == dtsh_pkg::OP_REC && present && ctl.depth >= thr
			&& pass_q < dtsh_pkg::PASS_MAX) begin
			pass_q <= pass_q + 1'b1;
		end
	end

	// update pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= (ctl.op == dtsh_pkg::OP_UPD) && present
				&& ({1'b0, ctl.addr} < pass_q);
		end
	end

	// share counter bank: read every cycle, write on clear or increment
	always_ff @(posedge clk) begin
		addr_s1 <= ctl.addr;
		rd_q    <= mem[ctl.addr];
		if (ctl.op == dtsh_pkg::OP_CLR) begin
			mem[ctl.addr] <= '0;
		end else if (en_s1) begin
			mem[addr_s1] <= (rd_q == dtsh_pkg::COUNT_MAX) ? rd_q : rd_q + 1'b1;
		end
	end

	assign stat.present = present;
	assign stat.thr     = thr;
	assign stat.rd      = rd_q;

endmodule

// ----- tb/tb_depth_threshold_sharing_histogram_top.sv -----
// ----------------------------------------------------------------------------
// tb_depth_threshold_sharing_histogram_top
// Checks the depth threshold sharing histogram against a behavioral
// predictor: depth records build share counts, and read beats are compared
// field by field. The stream covers several threshold settings and random
// stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_depth_threshold_sharing_histogram_top;

	typedef struct packed {
		logic        kind;
		logic [15:0] depth;
		logic        last;
		logic [6:0]  samp;
		logic [3:0]  fidx;
	} item_t;

	typedef struct packed {
		logic [31:0] count;
		logic [15:0] thr;
		logic        present;
	} rslt_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	depth_threshold_sharing_histogram_top u_dut (.*);

	// predictor state
	logic [15:0] p_min, p_max, p_step;
	int unsigned pass_cnt[dtsh_pkg::MAX_FILTERS];
	logic [31:0] share_cnt[dtsh_pkg::MAX_SAMPLES][dtsh_pkg::MAX_FILTERS];

	item_t pending_items[$];
	rslt_t expected_reads[$];
	int    errors;
	int    reads_seen;
	int    cycle;
	bit    calm;        // no idling in the last part
	int    hold_off;    // long receiver stall, in cycles
	int    s_gap, m_gap;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic int build_thresholds(output logic [15:0] thr[dtsh_pkg::MAX_FILTERS]);
		int n;
		logic [16:0] t;
		n = 0;
		for (int i = 0; i < dtsh_pkg::MAX_FILTERS; i++) thr[i] = '0;
		if (p_max <= p_min) begin
			thr[0] = p_min;
			return 1;
		end
		t = {1'b0, p_min};
		while (t <= {1'b0, p_max} && n < dtsh_pkg::MAX_FILTERS) begin
			thr[n] = t[15:0];
			n++;
			t = t + p_step;
		end
		if (n < dtsh_pkg::MAX_FILTERS && thr[n-1] != p_max) begin
			thr[n] = p_max;
			n++;
		end
		return n;
	endfunction

	// apply one accepted item to the predictor
	task automatic predict_histogram(input item_t it);
		logic [15:0] thr[dtsh_pkg::MAX_FILTERS];
		int n;
		rslt_t r;
		n = build_thresholds(thr);
		if (!it.kind) begin
			for (int f = 0; f < n; f++)
				if (it.depth >= thr[f] && pass_cnt[f] < dtsh_pkg::MAX_SAMPLES) pass_cnt[f]++;
			if (it.last) begin
				for (int f = 0; f < n; f++)
					for (int s = 0; s < pass_cnt[f]; s++)
						if (share_cnt[s][f] != 32'hFFFF_FFFF) share_cnt[s][f]++;
				for (int f = 0; f < dtsh_pkg::MAX_FILTERS; f++) pass_cnt[f] = 0;
			end
		end else begin
			r = '0;
			if (it.fidx < n) begin
				r.present = 1;
				r.thr = thr[it.fidx];
				if (it.samp >= 1 && it.samp <= dtsh_pkg::MAX_SAMPLES)
					r.count = share_cnt[it.samp-1][it.fidx];
			end
			expected_reads.push_back(r);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		item_t nx;
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 0;
			s_axis_tuser <= 0;
			s_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_histogram(pending_items.pop_front());
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (s_gap > 0) begin
					s_gap <= s_gap - 1;
					s_axis_tvalid <= 0;
				end else if (pending_items.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)
						&& pending_items.size() > 0) begin
					nx = pending_items[0];
					s_axis_tvalid <= 1;
					s_axis_tuser <= nx.kind;
					s_axis_tlast <= nx.last;
					s_axis_tdata <= {5'd0, nx.fidx, nx.samp, nx.depth};
					if (!calm && $urandom_range(0, 5) == 0) s_gap <= $urandom_range(1, 7);
				end else begin
					s_axis_tvalid <= 0;
				end
			end
		end
	end

	// long receiver stall countdown
	always @(posedge clk) begin
		if (hold_off > 0) hold_off <= hold_off - 1;
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		rslt_t got, exp_r;
		if (!arst_n) begin
			m_axis_tready <= 0;
			m_gap <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tuser};
				reads_seen++;
				if (expected_reads.size() == 0) begin
					errors++;
					$display("%0t: unexpected read beat, actual %h", $realtime, got);
				end else begin
					exp_r = expected_reads.pop_front();
					if (got.count !== exp_r.count) begin
						errors++;
						$display("%0t: count expected %0d actual %0d", $realtime,
							exp_r.count, got.count);
					end
					if (got.thr !== exp_r.thr) begin
						errors++;
						$display("%0t: threshold expected %0d actual %0d", $realtime,
							exp_r.thr, got.thr);
					end
					if (got.present !== exp_r.present) begin
						errors++;
						$display("%0t: present expected %0b actual %0b", $realtime,
							exp_r.present, got.present);
					end
				end
			end
			if (hold_off > 0) begin
				m_axis_tready <= 0;
			end else if (m_gap > 0) begin
				m_gap <= m_gap - 1;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= 1;
				if (!calm && $urandom_range(0, 4) == 0) m_gap <= $urandom_range(1, 7);
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 3_000_000) begin
			$display("depth_threshold_sharing_histogram_top regression: fail");
			$finish;
		end
	end

	function automatic item_t rec(input logic [15:0] d, input logic l);
		item_t it;
		it = '0;
		it.depth = d;
		it.last = l;
		return it;
	endfunction

	function automatic item_t rd(input logic [6:0] s, input logic [3:0] f);
		item_t it;
		it = '0;
		it.kind = 1;
		it.samp = s;
		it.fidx = f;
		return it;
	endfunction

	task automatic wait_idle();
		while (pending_items.size() != 0 || s_axis_tvalid || expected_reads.size() != 0)
			@(posedge clk);
		// a tlast record may still be sweeping
		repeat (dtsh_pkg::MAX_SAMPLES + 10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		case (idx)
			dtsh_pkg::REG_MIN_DEPTH:  p_min = v;
			dtsh_pkg::REG_MAX_DEPTH:  p_max = v;
			dtsh_pkg::REG_DEPTH_STEP: p_step = v;
			default: ;
		endcase
	endtask

	// random stimulus: positions of well-formed records with reads mixed in
	task automatic random_phase(input int count);
		int k, nsamp, lo, hi;
		k = 0;
		lo = (p_min > 5) ? p_min - 5 : 0;
		hi = (p_max < 65530) ? p_max + 5 : 65535;
		while (k < count) begin
			if ($urandom_range(0, 3) == 0) begin
				pending_items.push_back(rd(7'($urandom_range(0, 127)),
					4'($urandom_range(0, 15))));
				k++;
			end else begin
				nsamp = $urandom_range(1, 6);
				for (int s = 0; s < nsamp; s++) begin
					if ($urandom_range(0, 9) == 0)
						pending_items.push_back(rec(16'($urandom), s == nsamp - 1));
					else
						pending_items.push_back(rec(16'($urandom_range(lo, hi)),
							s == nsamp - 1));
				end
				k += nsamp;
			end
		end
		for (int f = 0; f < 16; f++)
			pending_items.push_back(rd(7'($urandom_range(1, 8)), 4'(f)));
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		reads_seen = 0;
		cycle = 0;
		calm = 0;
		hold_off = 0;
		p_min = 10;
		p_max = 40;
		p_step = 9;
		for (int f = 0; f < dtsh_pkg::MAX_FILTERS; f++) begin
			pass_cnt[f] = 0;
			for (int s = 0; s < dtsh_pkg::MAX_SAMPLES; s++) share_cnt[s][f] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: depth extremes, too many samples, index and sample bounds
		pending_items.push_back(rec(16'd0, 0));
		pending_items.push_back(rec(16'hFFFF, 0));
		pending_items.push_back(rec(16'd10, 0));
		pending_items.push_back(rec(16'd40, 1));
		for (int i = 0; i < 70; i++) pending_items.push_back(rec(16'hFFFF, i == 69));
		pending_items.push_back(rd(7'd1, 4'd0));
		pending_items.push_back(rd(7'd64, 4'd4));
		pending_items.push_back(rd(7'd0, 4'd1));
		pending_items.push_back(rd(7'd65, 4'd1));
		pending_items.push_back(rd(7'd127, 4'd2));
		pending_items.push_back(rd(7'd2, 4'd5));
		pending_items.push_back(rd(7'd3, 4'd15));
		// reads queue up behind a long receiver stall
		hold_off = 300;
		for (int i = 0; i < 40; i++) pending_items.push_back(rd(7'(i + 1), 4'(i % 16)));
		wait_idle();

		// zero step: list repeats min
		write_reg(dtsh_pkg::REG_DEPTH_STEP, 16'd0);
		write_reg(dtsh_pkg::REG_MIN_DEPTH, 16'd100);
		write_reg(dtsh_pkg::REG_MAX_DEPTH, 16'd200);
		pending_items.push_back(rec(16'd150, 1));
		for (int f = 0; f < 16; f++) pending_items.push_back(rd(7'd1, 4'(f)));
		wait_idle();

		// max not above min, then a full range with the largest step
		write_reg(dtsh_pkg::REG_MAX_DEPTH, 16'd50);
		random_phase(60);
		wait_idle();
		write_reg(dtsh_pkg::REG_MIN_DEPTH, 16'd0);
		write_reg(dtsh_pkg::REG_MAX_DEPTH, 16'hFFFF);
		write_reg(dtsh_pkg::REG_DEPTH_STEP, 16'hFFFF);
		random_phase(60);
		wait_idle();

		// full list cut at sixteen entries
		write_reg(dtsh_pkg::REG_DEPTH_STEP, 16'd3000);
		random_phase(120);
		wait_idle();
		write_reg(dtsh_pkg::REG_MIN_DEPTH, 16'd20);
		write_reg(dtsh_pkg::REG_MAX_DEPTH, 16'd90);
		write_reg(dtsh_pkg::REG_DEPTH_STEP, 16'd7);
		random_phase(120);
		wait_idle();

		// last part without idling
		write_reg(dtsh_pkg::REG_MIN_DEPTH, 16'hFFFF);
		write_reg(dtsh_pkg::REG_MAX_DEPTH, 16'hFFFF);
		write_reg(dtsh_pkg::REG_DEPTH_STEP, 16'd1);
		calm = 1;
		random_phase(80);
		wait_idle();

		$display("Covered records, reads and seven threshold settings; %0d read beats checked.",
			reads_seen);
		if (errors == 0 && expected_reads.size() == 0)
			$display("depth_threshold_sharing_histogram_top regression: pass");
		else
			$display("depth_threshold_sharing_histogram_top regression: fail");
		$finish;
	end

endmodule
